// ===== rtl/jtco_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtco_pkg
// Shared types, register codes and joint tables for the torque conditioning
// observer.
// ----------------------------------------------------------------------------
package jtco_pkg;

	typedef enum logic [2:0] {
		REG_FILTER_ALPHA    = 3'd0,
		REG_OBSERVER_GAIN   = 3'd1,
		REG_OBSERVER_STEP   = 3'd2,
		REG_LIMIT_BUFFER    = 3'd3,
		REG_LIMIT_STIFFNESS = 3'd4
	} jtco_reg_t;

	localparam logic [16:0] ALPHA_ONE = 17'd65536;

	typedef struct packed {
		logic [2:0]         joint_index;
		logic signed [31:0] joint_position;
		logic signed [31:0] joint_velocity;
		logic signed [31:0] command_torque;
		logic signed [31:0] gravity_torque;
		logic signed [31:0] joint_momentum;
		logic signed [31:0] model_torque;
		logic               stop_drive;
	} jtco_in_t;

	typedef struct packed {
		logic signed [31:0] drive_torque;
		logic signed [31:0] external_torque_estimate;
		logic               drive_applied;
	} jtco_out_t;

	// register values as used by the datapath (alpha already clamped to one)
	typedef struct packed {
		logic [16:0] alpha;
		logic [24:0] gain;
		logic [24:0] step;
		logic [19:0] buffer;
		logic [25:0] stiffness;
	} jtco_cfg_t;

	typedef struct packed {
		logic signed [31:0] filtered;
		logic signed [31:0] residual;
		logic signed [31:0] prev_momentum;
		logic signed [31:0] last_applied;
	} jtco_state_t;

	typedef struct packed {
		logic               en;
		logic               la_en;
		logic [2:0]         idx;
		logic signed [31:0] filtered;
		logic signed [31:0] residual;
		logic signed [31:0] prev_momentum;
	} jtco_wb_t;

	function automatic logic [3:0] jtco_damp(input logic [2:0] j);
		logic [3:0] d;
		unique case (j)
			3'd0, 3'd1, 3'd2, 3'd3: d = 4'd10;
			3'd4, 3'd5:             d = 4'd5;
			3'd6:                   d = 4'd2;
			default:                d = 4'd0;
		endcase
		return d;
	endfunction

	function automatic logic jtco_has_lim(input logic [2:0] j);
		return j != 3'd7;
	endfunction

	function automatic logic signed [31:0] jtco_lo(input logic [2:0] j);
		logic signed [31:0] v;
		unique case (j)
			3'd0:    v = -32'sd179811;
			3'd1:    v = -32'sd116897;
			3'd2:    v = -32'sd190100;
			3'd3:    v = -32'sd199367;
			3'd4:    v = -32'sd183927;
			3'd5:    v = 32'sd35684;
			3'd6:    v = -32'sd197650;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] jtco_hi(input logic [2:0] j);
		logic signed [31:0] v;
		unique case (j)
			3'd0:    v = 32'sd179811;
			3'd1:    v = 32'sd116897;
			3'd2:    v = 32'sd190100;
			3'd3:    v = -32'sd9948;
			3'd4:    v = 32'sd183927;
			3'd5:    v = 32'sd296020;
			3'd6:    v = 32'sd197650;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] jtco_sat32(input logic signed [63:0] v);
		logic signed [31:0] s;
		if (v > 64'sd2147483647)
			s = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			s = 32'sh80000000;
		else
			s = v[31:0];
		return s;
	endfunction

endpackage

// ===== rtl/jtco_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtco_cfg
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module jtco_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [25:0]       cfg_data,
	output jtco_pkg::jtco_cfg_t cfg
);

	logic [16:0] alpha_q;
	logic [24:0] gain_q;
	logic [24:0] step_q;
	logic [19:0] buffer_q;
	logic [25:0] stiff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= 17'd25290;
			gain_q   <= 25'd3276800;
			step_q   <= 25'd16777;
			buffer_q <= 20'd9830;
			stiff_q  <= 26'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				jtco_pkg::REG_FILTER_ALPHA:    alpha_q  <= cfg_data[16:0];
				jtco_pkg::REG_OBSERVER_GAIN:   gain_q   <= cfg_data[24:0];
				jtco_pkg::REG_OBSERVER_STEP:   step_q   <= cfg_data[24:0];
				jtco_pkg::REG_LIMIT_BUFFER:    buffer_q <= cfg_data[19:0];
				jtco_pkg::REG_LIMIT_STIFFNESS: stiff_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// weight above one clamps to one
	assign cfg.alpha     = (alpha_q > jtco_pkg::ALPHA_ONE) ? jtco_pkg::ALPHA_ONE : alpha_q;
	assign cfg.gain      = gain_q;
	assign cfg.step      = step_q;
	assign cfg.buffer    = buffer_q;
	assign cfg.stiffness = stiff_q;

endmodule

// ===== rtl/jtco_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtco_state
// Per-joint observer and filter state, cleared at reset.
// ----------------------------------------------------------------------------
module jtco_state #(
	parameter int JOINTS = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [2:0]            rd_idx,
	output jtco_pkg::jtco_state_t rd,
	input  jtco_pkg::jtco_wb_t    wb
);

	localparam int IW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	jtco_pkg::jtco_state_t st_q [JOINTS];
	logic [IW-1:0] ri;
	logic [IW-1:0] wi;

	assign ri = IW'(rd_idx);
	assign wi = IW'(wb.idx);
	// out-of-range reads are discarded downstream
	assign rd = st_q[ri];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOINTS; i++)
				st_q[i] <= '0;
		end else if (wb.en) begin
			st_q[wi].filtered      <= wb.filtered;
			st_q[wi].residual      <= wb.residual;
			st_q[wi].prev_momentum <= wb.prev_momentum;
			if (wb.la_en)
				st_q[wi].last_applied <= wb.filtered;
		end
	end

endmodule

// ===== rtl/jtco_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtco_pipe
// Five-stage observer and filter datapath with per-stage flow control and
// same-joint interlock.
// ----------------------------------------------------------------------------
module jtco_pipe #(
	parameter int JOINTS = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  jtco_pkg::jtco_in_t    sample,
	output logic                  result_valid,
	input  logic                  result_stall,
	output jtco_pkg::jtco_out_t   result,
	input  jtco_pkg::jtco_cfg_t   cfg,
	input  jtco_pkg::jtco_state_t rd,
	output jtco_pkg::jtco_wb_t    wb
);

	localparam logic [4:0] NJ = 5'(JOINTS);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;
	logic hazard, accept;

	// stage 1 payload
	logic [2:0]         idx_s1;
	logic               ok_s1, fin_s1, rep_en_s1, rep_neg_s1;
	logic signed [33:0] inner_s1;
	logic signed [32:0] pd_s1;
	logic signed [36:0] tota_s1;
	logic signed [33:0] dlt_s1;
	logic signed [31:0] p_s1, r_s1, f_s1;
	// stage 2
	logic [2:0]         idx_s2;
	logic               ok_s2, fin_s2, rep_en_s2, rep_neg_s2;
	logic signed [59:0] prod1_s2;
	logic signed [60:0] prodr_s2;
	logic signed [32:0] pd_s2;
	logic signed [36:0] tota_s2;
	logic signed [31:0] p_s2, r_s2, f_s2;
	// stage 3
	logic [2:0]         idx_s3;
	logic               ok_s3, fin_s3;
	logic signed [36:0] diff_s3;
	logic signed [32:0] fd_s3;
	logic signed [31:0] p_s3, r_s3, f_s3;
	// stage 4
	logic [2:0]         idx_s4;
	logic               ok_s4, fin_s4;
	logic signed [62:0] prod2_s4;
	logic signed [50:0] fprod_s4;
	logic signed [31:0] p_s4, r_s4, f_s4;
	// output stage
	jtco_pkg::jtco_out_t res_s5;

	// flow control: a stage moves when it is empty or its successor moves
	assign en5 = !v_s5 || !result_stall;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	// state is read at entry and written leaving stage 4
	assign hazard = (v_s1 && idx_s1 == sample.joint_index) ||
	                (v_s2 && idx_s2 == sample.joint_index) ||
	                (v_s3 && idx_s3 == sample.joint_index) ||
	                (v_s4 && idx_s4 == sample.joint_index);
	assign sample_stall = !en1 || hazard;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= accept;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// ---- stage 1: sums, damping, limit distance
	logic               ok_c, lo_hit, hi_hit, has_lim;
	logic [3:0]         damp;
	logic signed [36:0] dd;
	logic signed [32:0] dlo, dhi, dsel, bufs;

	always_comb begin
		ok_c    = {2'b00, sample.joint_index} < NJ;
		damp    = jtco_pkg::jtco_damp(sample.joint_index);
		dd      = 37'($signed({1'b0, damp}) * sample.joint_velocity);
		has_lim = jtco_pkg::jtco_has_lim(sample.joint_index);
		bufs    = 33'($signed({1'b0, cfg.buffer}));
		dlo     = 33'(sample.joint_position) - 33'(jtco_pkg::jtco_lo(sample.joint_index));
		dhi     = 33'(jtco_pkg::jtco_hi(sample.joint_index)) - 33'(sample.joint_position);
		lo_hit  = has_lim && (dlo < bufs);
		hi_hit  = has_lim && (dhi < bufs);
		dsel    = hi_hit ? dhi : dlo;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1     <= sample.joint_index;
			ok_s1      <= ok_c;
			fin_s1     <= sample.stop_drive;
			rep_en_s1  <= lo_hit || hi_hit;
			rep_neg_s1 <= hi_hit;
			inner_s1   <= 34'(rd.last_applied) - 34'(sample.model_torque) + 34'(rd.residual);
			pd_s1      <= 33'(sample.joint_momentum) - 33'(rd.prev_momentum);
			tota_s1    <= 37'(sample.command_torque) + 37'(sample.gravity_torque) - dd;
			dlt_s1     <= 34'(bufs) - 34'(dsel);
			p_s1       <= sample.joint_momentum;
			r_s1       <= rd.residual;
			f_s1       <= rd.filtered;
		end
	end

	// ---- stage 2: dt product and repulsion product
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			idx_s2     <= idx_s1;
			ok_s2      <= ok_s1;
			fin_s2     <= fin_s1;
			rep_en_s2  <= rep_en_s1;
			rep_neg_s2 <= rep_neg_s1;
			prod1_s2   <= inner_s1 * $signed({1'b0, cfg.step});
			prodr_s2   <= dlt_s1 * $signed({1'b0, cfg.stiffness});
			pd_s2      <= pd_s1;
			tota_s2    <= tota_s1;
			p_s2       <= p_s1;
			r_s2       <= r_s1;
			f_s2       <= f_s1;
		end
	end

	// ---- stage 3: rounding, observer difference, saturated total
	logic signed [59:0] rsum1;
	logic signed [35:0] q1;
	logic signed [60:0] rsumr;
	logic signed [44:0] repv;
	logic signed [45:0] tsum;
	logic signed [31:0] total;

	always_comb begin
		rsum1 = prod1_s2 + (60'sd1 <<< 23);
		q1    = 36'(rsum1 >>> 24);
		rsumr = prodr_s2 + (61'sd1 <<< 15);
		repv  = 45'(rsumr >>> 16);
		tsum  = 46'(tota_s2);
		if (rep_en_s2)
			tsum = rep_neg_s2 ? tsum - 46'(repv) : tsum + 46'(repv);
		total = jtco_pkg::jtco_sat32(64'(tsum));
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			idx_s3  <= idx_s2;
			ok_s3   <= ok_s2;
			fin_s3  <= fin_s2;
			diff_s3 <= 37'(pd_s2) - 37'(q1);
			fd_s3   <= 33'(total) - 33'(f_s2);
			p_s3    <= p_s2;
			r_s3    <= r_s2;
			f_s3    <= f_s2;
		end
	end

	// ---- stage 4: gain product and filter blend product
	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			idx_s4   <= idx_s3;
			ok_s4    <= ok_s3;
			fin_s4   <= fin_s3;
			prod2_s4 <= diff_s3 * $signed({1'b0, cfg.gain});
			fprod_s4 <= fd_s3 * $signed({1'b0, cfg.alpha});
			p_s4     <= p_s3;
			r_s4     <= r_s3;
			f_s4     <= f_s3;
		end
	end

	// ---- stage 5: round, accumulate, saturate; write back and register result
	logic signed [62:0] rsum2;
	logic signed [46:0] rq2;
	logic signed [31:0] r_new;
	logic signed [51:0] fsum;
	logic signed [31:0] f_new;

	always_comb begin
		rsum2 = prod2_s4 + (63'sd1 <<< 15);
		rq2   = 47'(rsum2 >>> 16);
		r_new = jtco_pkg::jtco_sat32(64'(rq2) + 64'(r_s4));
		fsum  = 52'(fprod_s4) + (52'(f_s4) <<< 16) + (52'sd1 <<< 15);
		f_new = jtco_pkg::jtco_sat32(64'(fsum >>> 16));
	end

	assign wb.en            = en5 && v_s4 && ok_s4;
	assign wb.la_en         = !fin_s4;
	assign wb.idx           = idx_s4;
	assign wb.filtered      = f_new;
	assign wb.residual      = r_new;
	assign wb.prev_momentum = p_s4;

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			if (ok_s4) begin
				res_s5.drive_torque             <= f_new;
				res_s5.external_torque_estimate <= r_new;
				res_s5.drive_applied            <= !fin_s4;
			end else begin
				res_s5 <= '0;
			end
		end
	end

	assign result_valid = v_s5;
	assign result       = res_s5;

	// no two in-flight items of one joint ahead of write-back
	a_no_dup_12: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 |-> idx_s1 != idx_s2) else $error("joint twice in s1/s2");
	a_no_dup_34: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && v_s4 |-> idx_s3 != idx_s4 && !(v_s1 && idx_s1 == idx_s4))
		else $error("joint twice in flight");
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1 && idx_s1 == $past(sample.joint_index)) else $error("entry lost");
	a_wb: assert property (@(posedge clk) disable iff (!arst_n)
		wb.en |=> v_s5) else $error("write-back without result");

endmodule

// ===== rtl/joint_torque_conditioning_observer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_torque_conditioning_observer_core
// Per-joint momentum observer and low-pass drive torque conditioning.
// ----------------------------------------------------------------------------
// Usage:
//  - sample channel (sample_valid / sample_stall / sample): one joint per
//    transfer, Q16.16 fields. A transfer happens when valid is high and stall
//    is low.
//  - result channel (result_valid / result_stall / result): one result per
//    sample, in order: filtered drive torque, observer residual, applied flag.
//  - cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//    writes, always ready; write only while no sample is in flight.
//  - Result path: a sample passes registered stages s1 to s5 and
//    result_valid rises when it reaches s5; it leaves when result_stall is low.
//  - Throughput: one sample per cycle when not stalled. The per-joint state is
//    read at entry and written four stages later, so a sample for a joint still
//    in the first four stages is held off; round-robin over joints never waits.
//  - Result stall: each stage moves on when it is empty, so bubbles close up
//    and samples keep entering until the pipe is full; then sample_stall rises.
//  - Reset: all per-joint state clears to zero at once, registers take their
//    defaults, the pipe empties.
// ----------------------------------------------------------------------------
module joint_torque_conditioning_observer_core #(
	parameter int JOINTS = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  jtco_pkg::jtco_in_t  sample,
	output logic                result_valid,
	input  logic                result_stall,
	output jtco_pkg::jtco_out_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [25:0]         cfg_data
);

	jtco_pkg::jtco_cfg_t   cfg;
	jtco_pkg::jtco_state_t rd;
	jtco_pkg::jtco_wb_t    wb;

	// register writes never wait
	assign cfg_ready = 1'b1;

	jtco_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	jtco_state #(.JOINTS(JOINTS)) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (sample.joint_index),
		.rd     (rd),
		.wb     (wb)
	);

	jtco_pipe #(.JOINTS(JOINTS)) u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg          (cfg),
		.rd           (rd),
		.wb           (wb)
	);

endmodule
